[src/cma_eq_pkg.sv]
// shared constants for the constant modulus equalizer
`timescale 1ns / 1ps
package cma_eq_pkg;

  localparam int TAP_COUNT_DEF     = 7;
  localparam int HIST_DEPTH_DEF    = 256;
  localparam int SAMPLE_WIDTH_DEF  = 16;

  // weights are Q3.14 in 18 bits
  localparam int WGT_W  = 18;
  localparam int WGT_FR = 14;

  localparam int CFG_AW = 1;
  localparam int CFG_DW = 6;
  localparam logic [CFG_AW-1:0] REG_ENABLE = 1'd0;
  localparam logic [CFG_AW-1:0] REG_SPS    = 1'd1;
  localparam logic [CFG_DW-1:0] SPS_MIN    = 6'd2;
  localparam logic [CFG_DW-1:0] SPS_MAX    = 6'd40;
  localparam logic [CFG_DW-1:0] SPS_RESET  = 6'd2;

  localparam int ERR_W = 16;

  // step size: mu = round(0.0003 * 2^66 / (0.05 * 2^26 + power))
  localparam logic [55:0] MU_NUM = 56'd22136092888451462;
  localparam logic [21:0] MU_OFF = 22'd3355443;

  // floor(v / 1000) = (v * AVG_RECIP) >> AVG_SH, exact for v below 2^27
  localparam int          AVG_RECIP_W = 27;
  localparam logic [26:0] AVG_RECIP   = 27'd68719477;
  localparam int          AVG_SH      = 36;

endpackage

[src/cma_adaptive_equalizer_unit.sv]
// constant modulus adaptive equalizer: history and weight memories with a sequencer
`timescale 1ns / 1ps
// Complex equalizer with TAP_COUNT taps adapted by the constant modulus rule. Samples
// enter on the in_ stream (restart flag on tuser, batch end on tlast) and one word per
// sample leaves on the out_ stream (diverged flag on tuser). An equalized sample goes
// through a multiply-accumulate pass over the taps through the history and weight
// memory read ports, a restoring divider for the step size, and an update pass that
// writes every weight back. A passed-through sample (disabled, or samples_per_symbol
// outside 2..40) goes straight to the output register; a sample whose output
// overflows ends after the first pass. The next word is taken while a finished result
// still waits on the output register. The history is not swept after reset: a fill
// count with a wrap flag marks what was written since the last reinit, so there is no
// clearing pass.
module cma_adaptive_equalizer_unit
  import cma_eq_pkg::*;
#(
  parameter int TAP_COUNT     = TAP_COUNT_DEF,
  parameter int HISTORY_DEPTH = HIST_DEPTH_DEF,
  parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_we,
  input  logic [CFG_AW-1:0]                        cfg_addr,
  input  logic [CFG_DW-1:0]                        cfg_wdata,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // in_i, in_q
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]      in_tdata,
  // restart
  input  logic                                     in_tuser,
  input  logic                                     in_tlast,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // out_i, out_q, error_average
  output logic [((2*SAMPLE_WIDTH+16+7)/8)*8-1:0]   out_tdata,
  // diverged
  output logic                                     out_tuser
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int FRAC   = SW - 3;
  localparam int OUT_DW = ((2*SW+16+7)/8)*8;
  localparam int AW     = $clog2(HISTORY_DEPTH);
  localparam int KW     = $clog2(TAP_COUNT+1);
  localparam int WKW    = $clog2(TAP_COUNT);
  localparam int PW     = WGT_W + SW;
  localparam int ACC_W  = PW + 5;
  localparam int XP_W   = 2*SW + 1;
  localparam int POW_W  = 2*SW + 5;
  localparam int MAG_W  = 2*SW + 2;
  localparam int EW     = 2*SW + 3;
  localparam int E26_W  = 29;
  localparam int DEN_W  = 37;
  localparam int REM_W  = 69;
  localparam int MU_W   = 33;
  localparam int MUG_W  = MU_W + 1 + E26_W;
  localparam int G_W    = 28;
  localparam int ESQ_W  = 2*E26_W;
  localparam int C_W    = 2*SW + 1;
  localparam int C26_W  = 33;
  localparam int GC_W   = G_W + C26_W;
  localparam int WSQ_W  = 2*WGT_W + 1;
  localparam int NW_W   = 2*WGT_W + 5;
  localparam int AVGV_W = 26;
  localparam int SH     = 2*FRAC - 26;
  localparam int SH_DN  = (SH > 0) ? SH : 0;
  localparam int SH_UP  = (SH < 0) ? -SH : 0;
  localparam int CENTER = TAP_COUNT / 2;

  localparam logic signed [ACC_W-1:0] Y_HALF = ACC_W'(1) <<< (WGT_FR - 1);
  localparam logic signed [ACC_W-1:0] Y_LIM  = ACC_W'(1) <<< (SW - 1);
  localparam logic signed [EW-1:0]    E_ONE  = EW'(1) <<< (2*FRAC);
  localparam logic signed [EW-1:0]    E_TWO  = EW'(1) <<< (2*FRAC + 1);
  localparam logic signed [WGT_W-1:0] W_ONE  = WGT_W'(1) <<< WGT_FR;
  localparam logic signed [WGT_W-1:0] W_MAX  = {1'b0, {(WGT_W-1){1'b1}}};
  localparam logic signed [WGT_W-1:0] W_MIN  = {1'b1, {(WGT_W-1){1'b0}}};
  localparam logic [NW_W-1:0]         NORM_LIM = NW_W'(64'd8 << 28);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_MACA = 5'd1;
  localparam logic [4:0] S_MACB = 5'd2;
  localparam logic [4:0] S_MACC = 5'd3;
  localparam logic [4:0] S_Y    = 5'd4;
  localparam logic [4:0] S_E    = 5'd5;
  localparam logic [4:0] S_D0   = 5'd6;
  localparam logic [4:0] S_DIV  = 5'd7;
  localparam logic [4:0] S_G    = 5'd8;
  localparam logic [4:0] S_G2   = 5'd9;
  localparam logic [4:0] S_UPA  = 5'd10;
  localparam logic [4:0] S_UPB  = 5'd11;
  localparam logic [4:0] S_UPC  = 5'd12;
  localparam logic [4:0] S_UPD  = 5'd13;
  localparam logic [4:0] S_UPE  = 5'd14;
  localparam logic [4:0] S_FIN  = 5'd15;
  localparam logic [4:0] S_AVG  = 5'd16;
  localparam logic [4:0] S_OUT  = 5'd17;

  // round half up, dividing by 2^s
  function automatic logic signed [63:0] rsh(input logic signed [63:0] v, input int s);
    logic signed [63:0] half;
    half = (s > 0) ? (64'sd1 <<< (s - 1)) : 64'sd0;
    rsh = (v + half) >>> s;
  endfunction

  // rescale a product of two samples to 26 fraction bits
  function automatic logic signed [63:0] to26(input logic signed [63:0] v);
    if (SH_DN > 0) to26 = rsh(v, SH_DN);
    else           to26 = v <<< SH_UP;
  endfunction

  // control
  logic [4:0]               state_r;
  logic [KW-1:0]            k_r;
  logic [AW-1:0]            off_r;
  logic [AW-1:0]            cursor_r;
  logic                     wrapped_r;
  logic [TAP_COUNT-1:0]     wvalid_r;
  logic [5:0]               cnt_r;
  logic                     enable_r;
  logic [CFG_DW-1:0]        sps_r;
  logic                     publish_r;
  logic                     out_valid_r;
  logic [ERR_W-1:0]         running_r;
  logic [ERR_W-1:0]         published_r;

  // datapath
  logic signed [SW-1:0]     xin_i_r, xin_q_r;
  logic signed [PW-1:0]     pii_r, pqq_r, piq_r, pqi_r;
  logic signed [XP_W-1:0]   px_r;
  logic signed [ACC_W-1:0]  acc_i_r, acc_q_r;
  logic [POW_W-1:0]         pow_r;
  logic signed [SW-1:0]     y_i_r, y_q_r;
  logic signed [E26_W-1:0]  e26_r;
  logic [DEN_W-1:0]         den_r;
  logic [REM_W-1:0]         rem_r, dsh_r;
  logic [MU_W-1:0]          mu_r;
  logic signed [MUG_W-1:0]  mug_r;
  logic signed [G_W-1:0]    g_r;
  logic signed [ESQ_W-1:0]  esq_r;
  logic signed [C_W-1:0]    cre_r, cim_r;
  logic signed [GC_W-1:0]   gcr_r, gci_r;
  logic signed [WGT_W-1:0]  wi_r, wq_r, nwi_r, nwq_r;
  logic [NW_W-1:0]          norm_r;
  logic [AVGV_W-1:0]        avgv_r;
  logic signed [SW-1:0]     res_i_r, res_q_r;
  logic                     res_div_r;
  logic [OUT_DW-1:0]        out_data_r;
  logic                     out_div_r;

  // memories
  logic [2*SW-1:0]          hist_mem [HISTORY_DEPTH];
  logic [2*SW-1:0]          hist_rd_r;
  logic                     hval_r;
  logic [2*WGT_W-1:0]       wgt_mem [TAP_COUNT];
  logic [2*WGT_W-1:0]       wgt_rd_r;

  // combinational
  logic                     active;
  logic [AW-1:0]            spacing;
  logic [AW:0]              idx_w, off_sum;
  logic [AW-1:0]            hist_raddr, hist_waddr;
  logic                     hval_nxt, hist_we, wgt_we;
  logic [WKW-1:0]           kx;
  logic signed [SW-1:0]     xcur_i, xcur_q;
  logic signed [WGT_W-1:0]  wcur_i, wcur_q;
  logic signed [ACC_W-1:0]  yfi, yfq;
  logic                     y_ovf;
  logic signed [MAG_W-1:0]  mag;
  logic signed [EW-1:0]     e_raw, e_cl;
  logic signed [C26_W-1:0]  c26_re, c26_im;
  logic signed [63:0]       step_i, step_q, sum_i, sum_q, e2_full;
  logic signed [WGT_W-1:0]  sat_i, sat_q;
  logic signed [WSQ_W-1:0]  wsq;
  logic [ERR_W-1:0]         e2_sat;
  logic [AVGV_W-1:0]        avgv;
  logic [AVGV_W+AVG_RECIP_W-1:0] avgp;
  logic                     out_load;
  logic [ERR_W-1:0]         pub_new;

  assign active  = enable_r && (sps_r >= SPS_MIN) && (sps_r <= SPS_MAX);
  assign spacing = AW'(sps_r >> 1);
  assign kx      = k_r[WKW-1:0];

  always_comb begin
    if (cursor_r >= off_r) idx_w = {1'b0, cursor_r} - {1'b0, off_r};
    else idx_w = {1'b0, cursor_r} + (AW+1)'(HISTORY_DEPTH) - {1'b0, off_r};
    hist_raddr = idx_w[AW-1:0];
    // only entries written since the last reinit hold samples
    hval_nxt   = wrapped_r || (idx_w[AW-1:0] <= cursor_r);
    off_sum    = {1'b0, off_r} + {1'b0, spacing};
    if (off_sum >= (AW+1)'(HISTORY_DEPTH)) off_sum = off_sum - (AW+1)'(HISTORY_DEPTH);
  end

  assign in_tready  = (state_r == S_IDLE);
  assign hist_we    = in_tvalid && in_tready && active;
  assign hist_waddr = in_tuser ? '0 : cursor_r;
  assign wgt_we     = (state_r == S_UPD);

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_waddr] <= {in_tdata[2*SW-1:SW], in_tdata[SW-1:0]};
    hist_rd_r <= hist_mem[hist_raddr];
    hval_r    <= hval_nxt;
  end

  always_ff @(posedge clk) begin
    if (wgt_we) wgt_mem[kx] <= {sat_q, sat_i};
    wgt_rd_r <= wgt_mem[kx];
  end

  always_comb begin
    xcur_i = hval_r ? $signed(hist_rd_r[SW-1:0])    : '0;
    xcur_q = hval_r ? $signed(hist_rd_r[2*SW-1:SW]) : '0;
    if (wvalid_r[kx]) begin
      wcur_i = $signed(wgt_rd_r[WGT_W-1:0]);
      wcur_q = $signed(wgt_rd_r[2*WGT_W-1:WGT_W]);
    end else begin
      wcur_i = (kx == WKW'(CENTER)) ? W_ONE : '0;
      wcur_q = '0;
    end
  end

  always_comb begin
    yfi   = (acc_i_r + Y_HALF) >>> WGT_FR;
    yfq   = (acc_q_r + Y_HALF) >>> WGT_FR;
    y_ovf = (yfi < -Y_LIM) || (yfi >= Y_LIM) || (yfq < -Y_LIM) || (yfq >= Y_LIM);
    mag   = y_i_r * y_i_r + y_q_r * y_q_r;
    e_raw = E_ONE - EW'(mag);
    e_cl  = e_raw;
    if (e_raw > E_TWO) e_cl = E_TWO;
    if (e_raw < -E_TWO) e_cl = -E_TWO;
    c26_re = C26_W'(to26(64'(cre_r)));
    c26_im = C26_W'(to26(64'(cim_r)));
    step_i = rsh(64'(gcr_r), 42);
    step_q = rsh(64'(gci_r), 42);
    sum_i  = 64'(wi_r) + step_i;
    sum_q  = 64'(wq_r) + step_q;
    sat_i  = (sum_i > 64'(W_MAX)) ? W_MAX : ((sum_i < 64'(W_MIN)) ? W_MIN : WGT_W'(sum_i));
    sat_q  = (sum_q > 64'(W_MAX)) ? W_MAX : ((sum_q < 64'(W_MIN)) ? W_MIN : WGT_W'(sum_q));
    wsq    = nwi_r * nwi_r + nwq_r * nwq_r;
    e2_full = rsh(64'(esq_r), 38);
    e2_sat = (e2_full > 64'sd65535) ? 16'hFFFF : ERR_W'(e2_full);
    avgv   = AVGV_W'(running_r) * AVGV_W'(999) + AVGV_W'(e2_sat) + AVGV_W'(500);
    avgp   = avgv_r * AVG_RECIP;
  end

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_tready);
  assign pub_new  = publish_r ? running_r : published_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      off_r       <= '0;
      cursor_r    <= '0;
      wrapped_r   <= 1'b0;
      wvalid_r    <= '0;
      cnt_r       <= '0;
      enable_r    <= 1'b0;
      sps_r       <= SPS_RESET;
      publish_r   <= 1'b0;
      out_valid_r <= 1'b0;
      running_r   <= '0;
      published_r <= '0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cfg_we) begin
            unique case (cfg_addr)
              REG_ENABLE: enable_r <= cfg_wdata[0];
              REG_SPS:    sps_r    <= cfg_wdata;
              default: ;
            endcase
          end
          if (cfg_we || (in_tvalid && in_tuser)) begin
            cursor_r  <= '0;
            wrapped_r <= 1'b0;
            wvalid_r  <= '0;
            running_r <= '0;
          end
          if (in_tvalid) begin
            xin_i_r <= $signed(in_tdata[SW-1:0]);
            xin_q_r <= $signed(in_tdata[2*SW-1:SW]);
            k_r     <= '0;
            off_r   <= '0;
            acc_i_r <= '0;
            acc_q_r <= '0;
            pow_r   <= '0;
            norm_r  <= '0;
            if (active) begin
              publish_r <= in_tlast;
              state_r   <= S_MACA;
            end else begin
              publish_r <= 1'b0;
              res_i_r   <= $signed(in_tdata[SW-1:0]);
              res_q_r   <= $signed(in_tdata[2*SW-1:SW]);
              res_div_r <= 1'b0;
              state_r   <= S_OUT;
            end
          end
        end
        S_MACA: state_r <= S_MACB;
        S_MACB: begin
          pii_r   <= wcur_i * xcur_i;
          pqq_r   <= wcur_q * xcur_q;
          piq_r   <= wcur_i * xcur_q;
          pqi_r   <= wcur_q * xcur_i;
          px_r    <= xcur_i * xcur_i + xcur_q * xcur_q;
          state_r <= S_MACC;
        end
        S_MACC: begin
          acc_i_r <= acc_i_r + ACC_W'(pii_r) - ACC_W'(pqq_r);
          acc_q_r <= acc_q_r + ACC_W'(piq_r) + ACC_W'(pqi_r);
          pow_r   <= pow_r + POW_W'(px_r);
          off_r   <= off_sum[AW-1:0];
          if (k_r == KW'(TAP_COUNT - 1)) begin
            k_r     <= '0;
            state_r <= S_Y;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_MACA;
          end
        end
        S_Y: begin
          y_i_r <= yfi[SW-1:0];
          y_q_r <= yfq[SW-1:0];
          if (y_ovf) begin
            cursor_r  <= '0;
            wrapped_r <= 1'b0;
            wvalid_r  <= '0;
            running_r <= '0;
            res_i_r   <= xin_i_r;
            res_q_r   <= xin_q_r;
            res_div_r <= 1'b1;
            state_r   <= S_OUT;
          end else begin
            state_r <= S_E;
          end
        end
        S_E: begin
          e26_r   <= E26_W'(to26(64'(e_cl)));
          den_r   <= DEN_W'(MU_OFF) + DEN_W'(to26($signed({1'b0, 63'(pow_r)})));
          state_r <= S_D0;
        end
        S_D0: begin
          rem_r   <= REM_W'(MU_NUM) + REM_W'(den_r >> 1);
          dsh_r   <= REM_W'(den_r) << (MU_W - 1);
          mu_r    <= '0;
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          if (rem_r >= dsh_r) begin
            rem_r <= rem_r - dsh_r;
            mu_r  <= {mu_r[MU_W-2:0], 1'b1};
          end else begin
            mu_r  <= {mu_r[MU_W-2:0], 1'b0};
          end
          dsh_r <= dsh_r >> 1;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 6'(MU_W - 1)) state_r <= S_G;
        end
        S_G: begin
          mug_r   <= $signed({1'b0, mu_r}) * e26_r;
          state_r <= S_G2;
        end
        S_G2: begin
          g_r     <= G_W'(rsh(64'(mug_r), 36));
          esq_r   <= e26_r * e26_r;
          k_r     <= '0;
          off_r   <= '0;
          state_r <= S_UPA;
        end
        S_UPA: state_r <= S_UPB;
        S_UPB: begin
          cre_r   <= y_i_r * xcur_i + y_q_r * xcur_q;
          cim_r   <= y_q_r * xcur_i - y_i_r * xcur_q;
          wi_r    <= wcur_i;
          wq_r    <= wcur_q;
          state_r <= S_UPC;
        end
        S_UPC: begin
          gcr_r   <= g_r * c26_re;
          gci_r   <= g_r * c26_im;
          state_r <= S_UPD;
        end
        S_UPD: begin
          nwi_r        <= sat_i;
          nwq_r        <= sat_q;
          wvalid_r[kx] <= 1'b1;
          state_r      <= S_UPE;
        end
        S_UPE: begin
          norm_r <= norm_r + NW_W'(wsq);
          off_r  <= off_sum[AW-1:0];
          if (k_r == KW'(TAP_COUNT - 1)) begin
            k_r     <= '0;
            state_r <= S_FIN;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_UPA;
          end
        end
        S_FIN: begin
          if (norm_r > NORM_LIM) begin
            cursor_r  <= '0;
            wrapped_r <= 1'b0;
            wvalid_r  <= '0;
            running_r <= '0;
            res_i_r   <= xin_i_r;
            res_q_r   <= xin_q_r;
            res_div_r <= 1'b1;
            state_r   <= S_OUT;
          end else begin
            avgv_r  <= avgv;
            state_r <= S_AVG;
          end
        end
        S_AVG: begin
          running_r <= avgp[AVG_SH +: ERR_W];
          if (cursor_r == AW'(HISTORY_DEPTH - 1)) begin
            cursor_r  <= '0;
            wrapped_r <= 1'b1;
          end else begin
            cursor_r <= cursor_r + 1'b1;
          end
          res_i_r   <= y_i_r;
          res_q_r   <= y_q_r;
          res_div_r <= 1'b0;
          state_r   <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_data_r  <= OUT_DW'({pub_new, res_q_r, res_i_r});
            out_div_r   <= res_div_r;
            published_r <= pub_new;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_div_r;

  // tap counter stays inside the weight memory during both passes
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MACA || state_r == S_MACB || state_r == S_MACC ||
     state_r == S_UPA || state_r == S_UPB || state_r == S_UPC ||
     state_r == S_UPD || state_r == S_UPE) |-> (k_r < KW'(TAP_COUNT)))
    else $error("tap counter out of range");

  // divider remainder must stay below twice the shifted divisor
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> ({1'b0, rem_r} < {dsh_r, 1'b0}))
    else $error("step size quotient overflow");

  // a diverged word leaves the filter reinitialized
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && res_div_r) |-> (cursor_r == '0 && !wrapped_r && wvalid_r == '0))
    else $error("diverged without reinit");

  // weights are written only from the update pass
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |=> (wvalid_r[kx] && state_r == S_UPE))
    else $error("weight write lost");

endmodule
